// ===== hdl/nnue_pkg.sv =====
package nnue_pkg;

    // input actions
    localparam logic [2:0] ACT_LOAD_FW  = 3'd0;
    localparam logic [2:0] ACT_LOAD_FB  = 3'd1;
    localparam logic [2:0] ACT_LOAD_OW  = 3'd2;
    localparam logic [2:0] ACT_REFRESH  = 3'd3;
    localparam logic [2:0] ACT_ADD      = 3'd4;
    localparam logic [2:0] ACT_REMOVE   = 3'd5;
    localparam logic [2:0] ACT_EVALUATE = 3'd6;

    localparam logic [2:0] PIECE_MAX = 3'd5;
    localparam int unsigned NUM_FEATURES = 768;
    localparam int unsigned FEAT_W = 10;
    localparam logic [5:0] FLIP_MASK = 6'd56;
    localparam int signed SCALE_MUL = 400;

    typedef struct packed {
        logic [2:0]        action;
        logic [2:0]        piece;
        logic              color;
        logic [5:0]        square;
        logic [8:0]        element;
        logic signed [15:0] weight_value;
        logic              eval_side;
    } in_item_t;

    typedef struct packed {
        logic signed [26:0] score;
        logic               overflow;
    } out_item_t;

    // feature row index for one side
    function automatic logic [FEAT_W-1:0] row_of(input logic [2:0] piece,
                                                  input logic color,
                                                  input logic [5:0] square);
        logic [FEAT_W-1:0] r;
        begin
            r = (color ? FEAT_W'(384) : FEAT_W'(0)) + {1'b0, piece, 6'd0} + {4'd0, square};
            return r;
        end
    endfunction

endpackage

// ===== hdl/nnue_if.sv =====
interface nnue_in_if;
    logic                valid;
    logic                ready;
    nnue_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nnue_out_if;
    logic                valid;
    logic                ready;
    nnue_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/nnue_accumulator_and_evaluate_core.sv =====
// an evaluate result is offered after the run, drain, scale and output states
// one transaction at a time through the accumulator memories; the input is not ready after
// a refresh, an add/remove (two feature weight memory reads a lane) or an evaluate until
// the core returns to idle, longer while an earlier result is stalled; loads and ignored
// transactions can follow every cycle
// reset: asynchronous active low; a clearing pass over every lane zeroes the accumulators
module nnue_accumulator_and_evaluate_core #(
    parameter int HIDDEN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [31:0] cfg_data,
    nnue_in_if.sink            in_ch,
    nnue_out_if.source         out_ch
);
    nnue_core #(.HIDDEN(HIDDEN)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    // a stalled result stays offered
    a_ready_low_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    // no result without an evaluate transaction pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.data.action != nnue_pkg::ACT_EVALUATE
        |=> !$rose(out_ch.valid)) else $error("spurious result");
endmodule

// ===== hdl/nnue_core.sv =====
module nnue_core #(
    parameter int HIDDEN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [31:0] cfg_data,
    nnue_in_if.sink            in_ch,
    nnue_out_if.source         out_ch
);
    localparam int LW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int CW = $clog2(HIDDEN + 1);
    localparam int FWD = nnue_pkg::NUM_FEATURES * HIDDEN;
    localparam int FAW = $clog2(FWD);
    localparam int FEAT_W_L = nnue_pkg::FEAT_W;

    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_RUN, S_DRAIN, S_SCALE, S_OUT} state_t;

    // memories
    logic [15:0] fw_mem [FWD];
    logic [15:0] fb_mem [HIDDEN];
    logic [15:0] ow_us_mem [HIDDEN];
    logic [15:0] ow_th_mem [HIDDEN];
    logic [15:0] wacc_mem [HIDDEN];
    logic [15:0] bacc_mem [HIDDEN];

    state_t state_reg;
    logic [CW-1:0] lane_reg;
    logic [2:0] act_reg;
    logic stm_reg;
    logic [FEAT_W_L-1:0] wrow_reg, brow_reg;
    logic signed [31:0] bias_reg;
    logic rd_v_reg;
    logic [LW-1:0] rd_lane_reg;
    logic [15:0] fw_w_q, fw_b_q, fb_q, ow_us_q, ow_th_q, wacc_q, bacc_q;
    logic signed [47:0] sum_reg;
    logic signed [31:0] prod_a_reg, prod_b_reg;
    logic prod_v_reg;
    logic signed [41:0] scaled_reg;
    logic ovf_reg;
    logic out_v_reg;
    nnue_pkg::out_item_t out_reg;
    logic fw_sel;

    // for add/remove the second weight read uses the same memory in the cycle after the first
    logic [LW-1:0] lane;
    assign lane = lane_reg[LW-1:0];
    assign in_ch.ready = (state_reg == S_IDLE) && rst_n;
    assign out_ch.valid = out_v_reg;
    assign out_ch.data = out_reg;

    wire in_acc = in_ch.valid && in_ch.ready;
    nnue_pkg::in_item_t d;
    assign d = in_ch.data;

    // memory write and read ports
    logic [FAW-1:0] fw_addr;
    always_comb
    begin
        fw_addr = fw_sel ? FAW'(brow_reg * HIDDEN + lane) : FAW'(wrow_reg * HIDDEN + lane);
        if (in_acc && d.action == nnue_pkg::ACT_LOAD_FW)
            fw_addr = FAW'(nnue_pkg::row_of(d.piece, d.color, d.square) * HIDDEN
                           + int'(d.element));
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && d.action == nnue_pkg::ACT_LOAD_FW && d.piece <= nnue_pkg::PIECE_MAX
            && int'(d.element) < HIDDEN)
            fw_mem[fw_addr] <= d.weight_value;
        if (fw_sel)
            fw_b_q <= fw_mem[fw_addr];
        else
            fw_w_q <= fw_mem[fw_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && d.action == nnue_pkg::ACT_LOAD_FB && int'(d.element) < HIDDEN)
            fb_mem[d.element[LW-1:0]] <= d.weight_value;
        fb_q <= fb_mem[lane];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && d.action == nnue_pkg::ACT_LOAD_OW && int'(d.element) < HIDDEN)
            ow_us_mem[d.element[LW-1:0]] <= d.weight_value;
        if (in_acc && d.action == nnue_pkg::ACT_LOAD_OW && int'(d.element) >= HIDDEN
            && int'(d.element) < 2 * HIDDEN)
            ow_th_mem[LW'(int'(d.element) - HIDDEN)] <= d.weight_value;
        ow_us_q <= ow_us_mem[lane];
        ow_th_q <= ow_th_mem[lane];
    end

    // accumulator read-modify-write, read one cycle, write back the next
    logic acc_we;
    logic [15:0] w_new, b_new;
    always_comb
    begin
        acc_we = 1'b0;
        w_new = wacc_q;
        b_new = bacc_q;
        case (act_reg)
            nnue_pkg::ACT_REFRESH:
            begin
                w_new = fb_q;
                b_new = fb_q;
                acc_we = rd_v_reg;
            end
            nnue_pkg::ACT_ADD:
            begin
                w_new = wacc_q + fw_w_q;
                b_new = bacc_q + fw_b_q;
                acc_we = rd_v_reg;
            end
            nnue_pkg::ACT_REMOVE:
            begin
                w_new = wacc_q - fw_w_q;
                b_new = bacc_q - fw_b_q;
                acc_we = rd_v_reg;
            end
            default: acc_we = 1'b0;
        endcase
        if (state_reg == S_CLEAR)
        begin
            w_new = '0;
            b_new = '0;
            acc_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            wacc_mem[state_reg == S_CLEAR ? lane : rd_lane_reg] <= w_new;
            bacc_mem[state_reg == S_CLEAR ? lane : rd_lane_reg] <= b_new;
        end
        wacc_q <= wacc_mem[lane];
        bacc_q <= bacc_mem[lane];
    end

    // relu products
    logic signed [15:0] us_v, th_v;
    assign us_v = stm_reg ? $signed(bacc_q) : $signed(wacc_q);
    assign th_v = stm_reg ? $signed(wacc_q) : $signed(bacc_q);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            lane_reg <= '0;
            act_reg <= '0;
            stm_reg <= 1'b0;
            bias_reg <= '0;
            rd_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            fw_sel <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bias_reg <= cfg_data;
            rd_v_reg <= 1'b0;
            rd_lane_reg <= lane;
            prod_v_reg <= rd_v_reg && act_reg == nnue_pkg::ACT_EVALUATE;
            if (rd_v_reg)
            begin
                prod_a_reg <= (us_v[15] ? 32'sd0 : 32'(us_v)) * 32'($signed(ow_us_q));
                prod_b_reg <= (th_v[15] ? 32'sd0 : 32'(th_v)) * 32'($signed(ow_th_q));
            end
            if (prod_v_reg)
                sum_reg <= sum_reg + 48'(prod_a_reg) + 48'(prod_b_reg);
            // result taken; a new one loaded in S_OUT keeps valid high instead
            if (out_ch.valid && out_ch.ready && state_reg != S_OUT)
                out_v_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    lane_reg <= lane_reg + 1'b1;
                    if (int'(lane_reg) == HIDDEN - 1)
                    begin
                        lane_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                    if (in_acc)
                    begin
                        act_reg <= d.action;
                        stm_reg <= d.eval_side;
                        wrow_reg <= nnue_pkg::row_of(d.piece, d.color, d.square);
                        brow_reg <= nnue_pkg::row_of(d.piece, ~d.color,
                                                     d.square ^ nnue_pkg::FLIP_MASK);
                        lane_reg <= '0;
                        fw_sel <= 1'b0;
                        sum_reg <= '0;
                        if (d.action == nnue_pkg::ACT_REFRESH
                            || d.action == nnue_pkg::ACT_EVALUATE
                            || ((d.action == nnue_pkg::ACT_ADD
                                 || d.action == nnue_pkg::ACT_REMOVE)
                                && d.piece <= nnue_pkg::PIECE_MAX))
                            state_reg <= S_RUN;
                    end
                S_RUN:
                begin
                    // add/remove reads two feature weights a lane (white then black row)
                    if ((act_reg == nnue_pkg::ACT_ADD || act_reg == nnue_pkg::ACT_REMOVE)
                        && !fw_sel)
                        fw_sel <= 1'b1;
                    else
                    begin
                        fw_sel <= 1'b0;
                        rd_v_reg <= 1'b1;
                        lane_reg <= lane_reg + 1'b1;
                        if (int'(lane_reg) == HIDDEN - 1)
                        begin
                            lane_reg <= '0;
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                    if (!rd_v_reg && !prod_v_reg)
                        state_reg <= (act_reg == nnue_pkg::ACT_EVALUATE) ? S_SCALE : S_IDLE;
                S_SCALE:
                begin
                    scaled_reg <= 42'($signed(32'(sum_reg) + bias_reg)) * 42'(nnue_pkg::SCALE_MUL);
                    ovf_reg <= (sum_reg > 48'sh7FFFFFFF) || (sum_reg < -48'sh80000000);
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_v_reg || out_ch.ready)
                    begin
                        out_reg.score <= 27'((scaled_reg + (scaled_reg[41] ? 42'sd16383 : 42'sd0))
                                             >>> 14);
                        out_reg.overflow <= ovf_reg;
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
